FILE: design/srme_pkg.sv
`default_nettype none

package srme_pkg;

	localparam int unsigned REGISTER_COUNT    = 6;
	localparam int unsigned PROGRAM_DEPTH_DEF = 256;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned OPCODE_W  = 4;
	localparam int unsigned OPERAND_W = 31;
	localparam int unsigned REGIDX_W  = 3;
	localparam int unsigned ADDR_W    = 8;
	localparam int unsigned LENGTH_W  = 9;

	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 48;

	localparam int unsigned CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_POINTER_REGISTER = 2'd0,
		CFG_START_VALUE      = 2'd1,
		CFG_PROGRAM_LENGTH   = 2'd2
	} cfg_index_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADDR = 4'd0,
		OP_ADDI = 4'd1,
		OP_MULR = 4'd2,
		OP_MULI = 4'd3,
		OP_BANR = 4'd4,
		OP_BANI = 4'd5,
		OP_BORR = 4'd6,
		OP_BORI = 4'd7,
		OP_SETR = 4'd8,
		OP_SETI = 4'd9,
		OP_GTIR = 4'd10,
		OP_GTRI = 4'd11,
		OP_GTRR = 4'd12,
		OP_EQIR = 4'd13,
		OP_EQRI = 4'd14,
		OP_EQRR = 4'd15
	} opcode_t;

	typedef enum logic {
		CMD_EXECUTE = 1'b0,
		CMD_RESTART = 1'b1
	} command_t;

endpackage

`default_nettype wire

FILE: design/six_register_machine_execute.sv
// A transaction accepted on s_axis is held in the input register and executes once the result
// register is free or being taken; its result is then valid on m_axis (input register, then
// result register). Throughput: one instruction per cycle unless m_axis stalls; the register
// file and pointer update in the cycle the result is registered, so the next instruction sees
// them directly. Reset: arst_n clears registers, pointer, halt flag, configuration and all valid flags.
`default_nettype none

module six_register_machine_execute
	import srme_pkg::*;
#(
	parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	// configuration write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]      cfg_data,

	// instruction stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// tdata: opcode[3:0], operand_a[34:4], operand_b[65:35], dest_index[68:66], zero pad
	input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: command (0 execute, 1 restart)
	input  wire logic                   s_axis_tuser,

	// result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// tdata: next_address[7:0], halted[8], fault[9], dest_value[41:10], zero pad
	output logic [OUT_DATA_W-1:0]       m_axis_tdata
);

	// pointer never reaches the program depth, so it needs only this many bits
	localparam int unsigned IP_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [REGIDX_W-1:0] ptr_reg_q;
	logic [WORD_W-1:0]   start_value_q;
	logic [LENGTH_W-1:0] prog_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_reg_q     <= '0;
			start_value_q <= '0;
			prog_len_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POINTER_REGISTER: ptr_reg_q     <= cfg_data[REGIDX_W-1:0];
				CFG_START_VALUE:      start_value_q <= cfg_data;
				CFG_PROGRAM_LENGTH:   prog_len_q    <= cfg_data[LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the configured length to the program depth
	logic [WORD_W-1:0] eff_len;
	always_comb begin
		if (WORD_W'(prog_len_q) > WORD_W'(PROGRAM_DEPTH))
			eff_len = WORD_W'(PROGRAM_DEPTH);
		else
			eff_len = WORD_W'(prog_len_q);
	end

	// ---------------------------------------------------------------
	// Input register stage
	// ---------------------------------------------------------------
	logic                 valid_s1;
	logic                 cmd_s1;
	logic [OPCODE_W-1:0]  op_s1;
	logic [OPERAND_W-1:0] a_s1;
	logic [OPERAND_W-1:0] b_s1;
	logic [REGIDX_W-1:0]  c_s1;

	logic fire;      // instruction in s1 executes and its result is registered
	logic in_take;

	assign fire          = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1 <= s_axis_tuser;
			op_s1  <= s_axis_tdata[3:0];
			a_s1   <= s_axis_tdata[34:4];
			b_s1   <= s_axis_tdata[65:35];
			c_s1   <= s_axis_tdata[68:66];
		end
	end

	// ---------------------------------------------------------------
	// Machine state
	// ---------------------------------------------------------------
	logic [WORD_W-1:0] rf_q [REGISTER_COUNT];
	logic [IP_W-1:0]   ip_q;
	logic              halt_q;

	logic [WORD_W-1:0] ip_ext;
	logic              bound;
	logic [WORD_W-1:0] rf_view [REGISTER_COUNT];

	assign ip_ext = WORD_W'(ip_q);
	assign bound  = ptr_reg_q < REGIDX_W'(REGISTER_COUNT);

	// register file as seen after the pointer copy
	always_comb begin
		for (int i = 0; i < REGISTER_COUNT; i++) begin
			if (bound && ptr_reg_q == REGIDX_W'(i))
				rf_view[i] = ip_ext;
			else
				rf_view[i] = rf_q[i];
		end
	end

	// ---------------------------------------------------------------
	// Execute
	// ---------------------------------------------------------------
	logic              a_reg, b_reg, fault, stopped;
	logic [WORD_W-1:0] imm_a, imm_b, ra, rb, val, ptr_after, np;
	logic              np_halt;
	logic              do_write;

	assign imm_a = WORD_W'(a_s1);
	assign imm_b = WORD_W'(b_s1);

	always_comb begin
		unique case (op_s1) inside
			OP_SETI, OP_GTIR, OP_EQIR: a_reg = 1'b0;
			default:                   a_reg = 1'b1;
		endcase
		unique case (op_s1) inside
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
			OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: b_reg = 1'b1;
			default:                           b_reg = 1'b0;
		endcase
	end

	assign stopped = halt_q || (ip_ext >= eff_len);
	assign fault   = (a_reg && imm_a >= WORD_W'(REGISTER_COUNT))
		|| (b_reg && imm_b >= WORD_W'(REGISTER_COUNT))
		|| (c_s1 >= REGIDX_W'(REGISTER_COUNT));

	// operand reads; an index past the file reads zero, only reached on a fault
	always_comb begin
		ra = '0;
		rb = '0;
		for (int i = 0; i < REGISTER_COUNT; i++) begin
			if (a_s1 == OPERAND_W'(i)) ra = rf_view[i];
			if (b_s1 == OPERAND_W'(i)) rb = rf_view[i];
		end
	end

	always_comb begin
		unique case (op_s1)
			OP_ADDR: val = ra + rb;
			OP_ADDI: val = ra + imm_b;
			OP_MULR: val = WORD_W'(ra * rb);
			OP_MULI: val = WORD_W'(ra * imm_b);
			OP_BANR: val = ra & rb;
			OP_BANI: val = ra & imm_b;
			OP_BORR: val = ra | rb;
			OP_BORI: val = ra | imm_b;
			OP_SETR: val = ra;
			OP_SETI: val = imm_a;
			OP_GTIR: val = WORD_W'($signed(imm_a) > $signed(rb));
			OP_GTRI: val = WORD_W'($signed(ra) > $signed(imm_b));
			OP_GTRR: val = WORD_W'($signed(ra) > $signed(rb));
			OP_EQIR: val = WORD_W'(imm_a == rb);
			OP_EQRI: val = WORD_W'(ra == imm_b);
			default: val = WORD_W'(ra == rb);
		endcase
	end

	// bound register after the write back, then advance by one
	always_comb begin
		if (!fault && bound && c_s1 == ptr_reg_q)
			ptr_after = val;
		else
			ptr_after = ip_ext;
		np = ptr_after + WORD_W'(1);
	end

	assign np_halt  = np[WORD_W-1] || (np >= eff_len);
	assign do_write = fire && cmd_s1 == CMD_EXECUTE && !stopped && !fault;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REGISTER_COUNT; i++) rf_q[i] <= '0;
			ip_q   <= '0;
			halt_q <= 1'b0;
		end else if (fire) begin
			if (cmd_s1 == CMD_RESTART) begin
				// clear everything, load register zero from configuration
				rf_q[0] <= start_value_q;
				for (int i = 1; i < REGISTER_COUNT; i++) rf_q[i] <= '0;
				ip_q    <= '0;
				halt_q  <= (eff_len == '0);
			end else if (stopped) begin
				halt_q <= 1'b1;
			end else begin
				if (do_write) begin
					// pointer copy, destination write takes precedence
					for (int i = 0; i < REGISTER_COUNT; i++) begin
						if (c_s1 == REGIDX_W'(i))
							rf_q[i] <= val;
						else if (bound && ptr_reg_q == REGIDX_W'(i))
							rf_q[i] <= ip_ext;
					end
				end
				if (np_halt) begin
					halt_q <= 1'b1;
					ip_q   <= '0;
				end else begin
					ip_q <= np[IP_W-1:0];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic [ADDR_W-1:0] res_addr;
	logic              res_halt, res_fault;
	logic [WORD_W-1:0] res_val;

	always_comb begin
		res_addr  = '0;
		res_halt  = 1'b0;
		res_fault = 1'b0;
		res_val   = '0;
		if (cmd_s1 == CMD_RESTART) begin
			res_halt = (eff_len == '0);
		end else if (stopped) begin
			res_halt = 1'b1;
		end else begin
			res_fault = fault;
			res_val   = fault ? '0 : val;
			res_halt  = np_halt;
			res_addr  = np_halt ? '0 : np[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (fire) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_axis_tdata <= {6'b0, res_val, res_fault, res_halt, res_addr};
		end
	end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
	import srme_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_PRINTED = 40;
	localparam int unsigned HOLD_CYCLES = 80;

	// one instruction as it travels on the input stream
	typedef struct packed {
		command_t        cmd;
		opcode_t         op;
		logic [30:0]     a;
		logic [30:0]     b;
		logic [2:0]      c;
	} instr_t;

	// one execution outcome as it travels on the result stream (lowest field last)
	typedef struct packed {
		logic [31:0]     dest_value;
		logic            fault;
		logic            halted;
		logic [7:0]      next_address;
	} outcome_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data = '0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;

	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;

	six_register_machine_execute uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow machine: configuration mirror and architectural state.
	// ------------------------------------------------------------------
	logic [2:0]  shadow_ptr_reg = '0;
	logic [31:0] shadow_start = '0;
	logic [8:0]  shadow_length = '0;
	logic [31:0] shadow_regs [REGISTER_COUNT];
	logic [7:0]  shadow_ip = '0;
	logic        shadow_halt = 1'b0;

	instr_t      pending_instrs [$];
	outcome_t    expected_outcomes [$];
	int unsigned mismatches = 0;
	int unsigned outcomes_seen = 0;
	int unsigned cycles = 0;

	initial begin
		for (int i = 0; i < REGISTER_COUNT; i++) begin
			shadow_regs[i] = '0;
		end
	end

	function automatic logic reads_reg_a(opcode_t op);
		case (op)
			OP_SETI, OP_GTIR, OP_EQIR: reads_reg_a = 1'b0;
			default:                   reads_reg_a = 1'b1;
		endcase
	endfunction

	function automatic logic reads_reg_b(opcode_t op);
		case (op)
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
			OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: reads_reg_b = 1'b1;
			default:                            reads_reg_b = 1'b0;
		endcase
	endfunction

	// Advance the shadow machine by one instruction and return its outcome.
	function automatic outcome_t execute_instr(instr_t it);
		outcome_t    res;
		logic [31:0] len;
		logic [31:0] ra;
		logic [31:0] rb;
		logic [31:0] val;
		logic [31:0] np;
		logic [31:0] ia;
		logic [31:0] ib;
		logic        use_a;
		logic        use_b;
		logic        flt;
		logic        bound;

		res = '0;
		ra = '0;
		rb = '0;
		val = '0;
		ia = {1'b0, it.a};
		ib = {1'b0, it.b};
		len = (shadow_length > PROGRAM_DEPTH_DEF) ? PROGRAM_DEPTH_DEF : {23'd0, shadow_length};
		bound = (shadow_ptr_reg < REGISTER_COUNT);

		if (it.cmd == CMD_RESTART) begin
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				shadow_regs[i] = '0;
			end
			shadow_regs[0] = shadow_start;
			shadow_ip = '0;
			shadow_halt = (len == 0);
			res.halted = shadow_halt;
			return res;
		end

		// halted machine, or pointer left out of range by a shrunk program
		if (shadow_halt || {24'd0, shadow_ip} >= len) begin
			shadow_halt = 1'b1;
			res.halted = 1'b1;
			return res;
		end

		use_a = reads_reg_a(it.op);
		use_b = reads_reg_b(it.op);
		flt = (use_a && ia >= REGISTER_COUNT) || (use_b && ib >= REGISTER_COUNT) ||
			(it.c >= REGISTER_COUNT);

		if (flt) begin
			// no write at all, not even the pointer copy
			np = {24'd0, shadow_ip} + 32'd1;
		end else begin
			if (bound) begin
				shadow_regs[shadow_ptr_reg] = {24'd0, shadow_ip};
			end
			if (use_a) begin
				ra = shadow_regs[ia[2:0]];
			end
			if (use_b) begin
				rb = shadow_regs[ib[2:0]];
			end
			case (it.op)
				OP_ADDR: val = ra + rb;
				OP_ADDI: val = ra + ib;
				OP_MULR: val = ra * rb;
				OP_MULI: val = ra * ib;
				OP_BANR: val = ra & rb;
				OP_BANI: val = ra & ib;
				OP_BORR: val = ra | rb;
				OP_BORI: val = ra | ib;
				OP_SETR: val = ra;
				OP_SETI: val = ia;
				OP_GTIR: val = ($signed(ia) > $signed(rb)) ? 32'd1 : 32'd0;
				OP_GTRI: val = ($signed(ra) > $signed(ib)) ? 32'd1 : 32'd0;
				OP_GTRR: val = ($signed(ra) > $signed(rb)) ? 32'd1 : 32'd0;
				OP_EQIR: val = (ia == rb) ? 32'd1 : 32'd0;
				OP_EQRI: val = (ra == ib) ? 32'd1 : 32'd0;
				default: val = (ra == rb) ? 32'd1 : 32'd0;
			endcase
			shadow_regs[it.c] = val;
			np = bound ? shadow_regs[shadow_ptr_reg] + 32'd1 : {24'd0, shadow_ip} + 32'd1;
			res.dest_value = val;
		end

		if (np[31] || np >= len) begin
			shadow_halt = 1'b1;
			shadow_ip = '0;
			res.halted = 1'b1;
		end else begin
			shadow_ip = np[7:0];
			res.next_address = np[7:0];
		end
		res.fault = flt;
		return res;
	endfunction

	function automatic instr_t instr(command_t cmd, opcode_t op, logic [30:0] a,
		logic [30:0] b, logic [2:0] c);
		instr_t it;
		it.cmd = cmd;
		it.op = op;
		it.a = a;
		it.b = b;
		it.c = c;
		return it;
	endfunction

	// add an instruction at the tail of the pending queue
	function automatic void append_instr(instr_t it);
		pending_instrs.insert(pending_instrs.size(), it);
	endfunction

	function automatic logic [30:0] random_imm();
		logic [30:0] v;
		if ($urandom_range(0, 1) == 0) begin
			v = 31'($urandom_range(0, 300));
		end else begin
			v = 31'($urandom());
		end
		return v;
	endfunction

	function automatic logic [30:0] random_reg_ref();
		logic [30:0] v;
		if ($urandom_range(0, 24) == 0) begin
			v = 31'($urandom_range(REGISTER_COUNT, 32'h7FFF_FFFF));
		end else begin
			v = 31'($urandom_range(0, REGISTER_COUNT - 1));
		end
		return v;
	endfunction

	// Mostly well-formed instructions with random content; restarts keep
	// the machine alive, occasional faults and pointer writes add noise.
	function automatic instr_t random_instr();
		instr_t it;
		it.op = opcode_t'(4'($urandom_range(0, 15)));
		it.a = reads_reg_a(it.op) ? random_reg_ref() : random_imm();
		it.b = reads_reg_b(it.op) ? random_reg_ref() : random_imm();
		it.c = 3'($urandom_range(0, REGISTER_COUNT - 1));
		if (it.c == shadow_ptr_reg && $urandom_range(0, 9) != 0) begin
			it.c = 3'((it.c + 1) % REGISTER_COUNT);
		end
		if ($urandom_range(0, 14) == 0) begin
			it.c = 3'($urandom_range(REGISTER_COUNT, 7));
		end
		it.cmd = ($urandom_range(0, 9) == 0) ? CMD_RESTART : CMD_EXECUTE;
		if (it.cmd == CMD_RESTART) begin
			it.a = 31'($urandom());
			it.b = 31'($urandom());
		end
		return it;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_PRINTED) begin
			$display("mismatch at cycle %0d: %s", cycles, msg);
		end
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Driver: offer pending instructions in bursts separated by gaps.
	// ------------------------------------------------------------------
	instr_t      offered;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// predict at acceptance, so the shadow sees instructions in order
			if (s_axis_tvalid && s_axis_tready) begin
				expected_outcomes.insert(expected_outcomes.size(), execute_instr(offered));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_instrs.size() != 0) begin
					offered = pending_instrs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {3'd0, offered.c, offered.b, offered.a, offered.op};
					s_axis_tuser <= offered.cmd;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long hold-off: twice in the run, keep the result side closed while
	// the driver keeps offering, so the pipeline backs up into s_axis.
	// ------------------------------------------------------------------
	int unsigned hold_left = 0;
	int unsigned holds_taken = 0;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_taken < 2 && outcomes_seen >= 150 + 250 * holds_taken) begin
			hold_left <= HOLD_CYCLES;
			holds_taken <= holds_taken + 1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result transaction with the oldest expectation
	// and drive tready from a pattern that switches mode now and then.
	// ------------------------------------------------------------------
	int unsigned rx_mode = 0;
	int unsigned rx_mode_left = 0;
	logic        rx_toggle = 1'b0;
	logic        rx_ready;
	outcome_t    got;
	outcome_t    want;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[41:0];
			outcomes_seen <= outcomes_seen + 1;
			if (expected_outcomes.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected (tdata %h)",
					m_axis_tdata));
			end else begin
				want = expected_outcomes.pop_front();
				if (got.next_address !== want.next_address) begin
					report_mismatch($sformatf("next_address %0d, expected %0d",
						got.next_address, want.next_address));
				end
				if (got.halted !== want.halted) begin
					report_mismatch($sformatf("halted %b, expected %b",
						got.halted, want.halted));
				end
				if (got.fault !== want.fault) begin
					report_mismatch($sformatf("fault %b, expected %b",
						got.fault, want.fault));
				end
				if (got.dest_value !== want.dest_value) begin
					report_mismatch($sformatf("dest_value %h, expected %h",
						got.dest_value, want.dest_value));
				end
			end
		end

		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(20, 120);
		end else begin
			rx_mode_left--;
		end
		rx_toggle = ~rx_toggle;
		case (rx_mode)
			0:       rx_ready = 1'b1;
			1:       rx_ready = ($urandom_range(0, 9) < 7);
			2:       rx_ready = ($urandom_range(0, 9) < 3);
			default: rx_ready = rx_toggle;
		endcase
		m_axis_tready <= rx_ready && (hold_left == 0);
	end

	// Hard stop for a hung design.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing: reset, directed checks, then randomized phases.
	// ------------------------------------------------------------------

	// Wait until every offered instruction has come back; sample at the
	// falling edge so all posedge activity has settled.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_instrs.size() != 0 || s_axis_tvalid ||
			expected_outcomes.size() != 0);
	endtask

	task automatic write_cfg(cfg_index_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_POINTER_REGISTER: shadow_ptr_reg = value[2:0];
			CFG_START_VALUE:      shadow_start = value;
			default:              shadow_length = value[8:0];
		endcase
	endtask

	task automatic configure(logic [2:0] ptr, logic [31:0] start, logic [8:0] len);
		write_cfg(CFG_POINTER_REGISTER, {29'd0, ptr});
		write_cfg(CFG_START_VALUE, start);
		write_cfg(CFG_PROGRAM_LENGTH, {23'd0, len});
	endtask

	task automatic random_phase(logic [2:0] ptr, logic [31:0] start, logic [8:0] len,
		int unsigned count);
		configure(ptr, start, len);
		append_instr(instr(CMD_RESTART, OP_ADDR, 31'($urandom()), 31'($urandom()), 3'd0));
		for (int i = 0; i < count; i++) begin
			append_instr(random_instr());
		end
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration has a zero-length program: both forms halt.
		append_instr(instr(CMD_EXECUTE, OP_ADDI, 31'd0, 31'd1, 3'd1));
		append_instr(instr(CMD_RESTART, OP_ADDR, 31'd0, 31'd0, 3'd0));
		wait_drained();

		// Long program (clamped to the depth), start value of minus one,
		// pointer bound to register four.
		configure(3'd4, 32'hFFFF_FFFF, 9'd300);
		append_instr(instr(CMD_RESTART, OP_ADDR, 31'd0, 31'd0, 3'd0));
		// seti ignores B
		append_instr(instr(CMD_EXECUTE, OP_SETI, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 3'd1));
		append_instr(instr(CMD_EXECUTE, OP_SETI, 31'd0, 31'h1234_5678, 3'd2));
		// every other opcode once
		append_instr(instr(CMD_EXECUTE, OP_ADDR, 31'd0, 31'd1, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_ADDI, 31'd1, 31'h7FFF_FFFF, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_MULR, 31'd0, 31'd1, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_MULI, 31'd1, 31'h7FFF_FFFF, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_BANR, 31'd0, 31'd1, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_BANI, 31'd0, 31'h5555_5555, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_BORR, 31'd1, 31'd2, 3'd5));
		append_instr(instr(CMD_EXECUTE, OP_BORI, 31'd2, 31'h2AAA_AAAA, 3'd5));
		append_instr(instr(CMD_EXECUTE, OP_SETR, 31'd0, 31'h7FFF_FFFF, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_GTIR, 31'd0, 31'd0, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_GTRI, 31'd1, 31'h7FFF_FFFE, 3'd5));
		append_instr(instr(CMD_EXECUTE, OP_GTRR, 31'd0, 31'd1, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_EQIR, 31'h7FFF_FFFF, 31'd1, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_EQRI, 31'd2, 31'd0, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_EQRR, 31'd0, 31'd0, 3'd5));
		// register faults: bad A, bad B, both bad destinations
		append_instr(instr(CMD_EXECUTE, OP_ADDR, 31'd6, 31'd0, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_MULR, 31'd0, 31'h7FFF_FFFF, 3'd3));
		append_instr(instr(CMD_EXECUTE, OP_SETI, 31'd1, 31'd0, 3'd7));
		append_instr(instr(CMD_EXECUTE, OP_SETI, 31'd1, 31'd0, 3'd6));
		// jump through the pointer register, then drive it negative to halt
		append_instr(instr(CMD_EXECUTE, OP_SETI, 31'd250, 31'd0, 3'd4));
		append_instr(instr(CMD_EXECUTE, OP_ADDR, 31'd0, 31'd0, 3'd4));
		// execute while halted
		append_instr(instr(CMD_EXECUTE, OP_ADDI, 31'd0, 31'd1, 3'd0));
		wait_drained();

		// Randomized phases across pointer bindings (unbound ones too),
		// start-value extremes and program lengths from one to far past depth.
		random_phase(3'd0, $urandom(), 9'd64, 85);
		random_phase(3'd7, 32'h8000_0000, 9'd1, 85);
		random_phase(3'd5, 32'h7FFF_FFFF, 9'd256, 85);
		random_phase(3'd6, $urandom(), 9'd511, 85);
		random_phase(3'd2, $urandom_range(0, 40), 9'd16, 85);
		random_phase(3'd1, $urandom(), 9'($urandom_range(2, 200)), 85);

		// let any stray result show up before the verdict
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: six_register_machine_execute.f
design/srme_pkg.sv
design/six_register_machine_execute.sv
sim/tb_top.sv
